// ===== hdl/cmg_pkg.sv =====
package cmg_pkg;

    // fixed field widths of the request, result and register words
    localparam int MODULUS_W  = 32;
    localparam int POSITION_W = 7;
    localparam int SET_SIZE_W = 8;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 40;
    localparam int M_USER_W   = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    // defaults for the top-level parameters
    localparam int DEF_MAX_MODULI   = 128;
    localparam int DEF_MODULUS_BITS = 32;

    // register reset values
    localparam logic [MODULUS_W-1:0]  FIRST_MODULUS_RST = 32'd96997537;
    localparam logic [SET_SIZE_W-1:0] SET_SIZE_RST      = 8'd128;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_MODULUS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SET_SIZE      = 1'd1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_COMPLETE = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [MODULUS_W-1:0]  modulus;
        logic [POSITION_W-1:0] position;
        logic                  last;
        status_t               status;
    } result_t;

    typedef struct packed {
        logic done;
        logic coprime;
    } gcd_res_t;

endpackage

// ===== hdl/coprime_moduli_generator_unit.sv =====
// Channel   Dir  Handshake               Payload
// s_        in   s_tvalid / s_tready     s_tdata[0] restart (1: clear set, return first)
// m_        out  m_tvalid / m_tready     m_tdata modulus, position; m_tlast; m_tuser status
// cfg_      in   cfg_valid / cfg_ready   cfg_index 0 first_modulus, 1 set_size; cfg_data
//
// Restart, completion and immediate overflow words pass from the accept through
// ST_RESP into the output register before m_tvalid. A search adds one range check
// (ST_CHECK) per tested candidate and, per stored modulus, a table read, gcd start
// and gcd end (ST_FETCH, ST_START, ST_GCD) plus the binary gcd steps; an overflow
// found at the range check goes from ST_CHECK to ST_RESP. The one-step-per-cycle
// gcd unit and the single table read port set the search speed. One word is taken
// at a time; s_tready returns once ST_RESP has handed the word on.
// Reset (aresetn, synchronous) empties the set and restores both registers;
// the moduli table holds no reset value and needs no clearing pass.
// The result waits in an output register, so s_tready can return while m_tready is low if that register is empty.
module coprime_moduli_generator_unit import cmg_pkg::*; #(
    parameter int MAX_MODULI   = DEF_MAX_MODULI,
    parameter int MODULUS_BITS = DEF_MODULUS_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // request word
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_W-1:0]    s_tdata,   // [0] restart, [7:1] zero
    // result word
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_W-1:0]    m_tdata,   // [31:0] modulus, [38:32] position, [39] zero
    output logic                   m_tlast,   // modulus completes the set
    output logic [M_USER_W-1:0]    m_tuser,   // [1:0] status
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_MODULI);

    logic [MODULUS_W-1:0]  first_modulus_reg;
    logic [SET_SIZE_W-1:0] set_size_reg;

    logic                    res_valid, res_ready;
    result_t                 res;
    logic                    out_valid_reg;
    result_t                 out_reg;

    logic                    wr_en, rd_en;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic [MODULUS_BITS-1:0] wr_data, rd_data;
    logic                    gcd_start;
    logic [MODULUS_BITS-1:0] gcd_a, gcd_b;
    gcd_res_t                gcd_res;

    // configuration registers, to be written only while idle; not enforced by the block
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_modulus_reg <= FIRST_MODULUS_RST;
            set_size_reg      <= SET_SIZE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FIRST_MODULUS: first_modulus_reg <= cfg_data;
                CFG_SET_SIZE:      set_size_reg      <= cfg_data[SET_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    cmg_search #(
        .MAX_MODULI  (MAX_MODULI),
        .MODULUS_BITS(MODULUS_BITS)
    ) u_search (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_valid    (s_tvalid),
        .req_ready    (s_tready),
        .req_restart  (s_tdata[0]),
        .first_modulus(first_modulus_reg),
        .set_size     (set_size_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .gcd_start    (gcd_start),
        .gcd_a        (gcd_a),
        .gcd_b        (gcd_b),
        .gcd_res      (gcd_res)
    );

    // moduli table, one write and one registered read port
    cmg_ram #(
        .WIDTH(MODULUS_BITS),
        .DEPTH(MAX_MODULI)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    cmg_gcd #(
        .MODULUS_BITS(MODULUS_BITS)
    ) u_gcd (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (gcd_start),
        .a_in   (gcd_a),
        .b_in   (gcd_b),
        .res    (gcd_res)
    );

    // output register: frees the sequencer once the word is parked here
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.position, out_reg.modulus};
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.status;

endmodule

// ===== hdl/cmg_ram.sv =====
module cmg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/cmg_gcd.sv =====
// Binary gcd of two odd, nonzero operands; one shift or subtract per cycle.
module cmg_gcd import cmg_pkg::*; #(
    parameter int MODULUS_BITS = DEF_MODULUS_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [MODULUS_BITS-1:0] a_in,
    input  logic [MODULUS_BITS-1:0] b_in,
    output gcd_res_t                res
);

    localparam logic [MODULUS_BITS-1:0] ONE = MODULUS_BITS'(1);

    logic                    running_reg, running_next;
    logic [MODULUS_BITS-1:0] a_reg, a_next;
    logic [MODULUS_BITS-1:0] b_reg, b_next;
    logic                    unit_found, equal_found;

    assign unit_found  = (a_reg == ONE) || (b_reg == ONE);
    assign equal_found = (a_reg == b_reg);

    always_comb begin
        running_next = running_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        if (start) begin
            running_next = 1'b1;
            a_next       = a_in;
            b_next       = b_in;
        end else if (running_reg) begin
            if (unit_found || equal_found) begin
                running_next = 1'b0;
            end else if (!a_reg[0]) begin
                a_next = a_reg >> 1;
            end else if (!b_reg[0]) begin
                b_next = b_reg >> 1;
            end else if (a_reg > b_reg) begin
                a_next = a_reg - b_reg;
            end else begin
                b_next = b_reg - a_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
        end else begin
            running_reg <= running_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign res.done    = running_reg && (unit_found || equal_found);
    assign res.coprime = unit_found;

endmodule

// ===== hdl/cmg_search.sv =====
// Request sequencer: restart, candidate stepping, table walk, result build.
module cmg_search import cmg_pkg::*; #(
    parameter int MAX_MODULI   = DEF_MAX_MODULI,
    parameter int MODULUS_BITS = DEF_MODULUS_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          req_restart,
    input  logic [MODULUS_W-1:0]          first_modulus,
    input  logic [SET_SIZE_W-1:0]         set_size,
    output logic                          res_valid,
    input  logic                          res_ready,
    output result_t                       res,
    output logic                          wr_en,
    output logic [$clog2(MAX_MODULI)-1:0] wr_addr,
    output logic [MODULUS_BITS-1:0]       wr_data,
    output logic                          rd_en,
    output logic [$clog2(MAX_MODULI)-1:0] rd_addr,
    input  logic [MODULUS_BITS-1:0]       rd_data,
    output logic                          gcd_start,
    output logic [MODULUS_BITS-1:0]       gcd_a,
    output logic [MODULUS_BITS-1:0]       gcd_b,
    input  gcd_res_t                      gcd_res
);

    localparam int AW    = $clog2(MAX_MODULI);
    localparam int CW    = $clog2(MAX_MODULI + 1);
    localparam int EW    = (CW > SET_SIZE_W) ? CW : SET_SIZE_W;
    localparam int CANDW = MODULUS_BITS + 1;
    localparam logic [EW-1:0] MAX_E = EW'(MAX_MODULI);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FETCH,
        ST_START,
        ST_GCD,
        ST_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CANDW-1:0]  cand_reg, cand_next;
    logic              first_odd_reg, first_odd_next;
    result_t           res_reg, res_next;

    logic [EW-1:0]     eff;
    logic [EW-1:0]     count_e;
    logic              first_too_wide;
    logic [CW-1:0]     idx_inc;
    logic [63:0]       first_wide;
    logic [CANDW-1:0]  cand_inc;

    always_comb begin
        if (set_size == '0) begin
            eff = EW'(1);
        end else if (EW'(set_size) > MAX_E) begin
            eff = MAX_E;
        end else begin
            eff = EW'(set_size);
        end
    end

    assign count_e        = EW'(count_reg);
    assign first_wide     = 64'(first_modulus);
    assign first_too_wide = (first_wide >> MODULUS_BITS) != 64'd0;
    assign idx_inc        = idx_reg + CW'(1);
    assign cand_inc       = cand_reg + CANDW'(2);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cand_next      = cand_reg;
        first_odd_next = first_odd_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        wr_data        = cand_reg[MODULUS_BITS-1:0];
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];
        gcd_start      = 1'b0;
        gcd_a          = rd_data;
        gcd_b          = cand_reg[MODULUS_BITS-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    res_next = '{modulus: '0, position: '0, last: 1'b0,
                                 status: STATUS_OK};
                    state_next = ST_RESP;
                    if (req_restart || count_reg == '0) begin
                        count_next = '0;
                        if (first_too_wide) begin
                            res_next.status = STATUS_OVERFLOW;
                        end else begin
                            wr_en          = 1'b1;
                            wr_addr        = '0;
                            wr_data        = first_wide[MODULUS_BITS-1:0];
                            count_next     = CW'(1);
                            first_odd_next = first_modulus[0];
                            cand_next      = CANDW'(first_wide + 64'd2);
                            res_next.modulus = first_modulus;
                            res_next.last    = (eff <= EW'(1));
                        end
                    end else if (count_e >= eff) begin
                        res_next.status = STATUS_COMPLETE;
                    end else if (!first_odd_reg) begin
                        // even first modulus: search can only run out of range
                        res_next.status = STATUS_OVERFLOW;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (cand_reg[MODULUS_BITS]) begin
                    res_next.status = STATUS_OVERFLOW;
                    state_next      = ST_RESP;
                end else begin
                    idx_next   = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                rd_en      = 1'b1;
                state_next = ST_START;
            end
            ST_START: begin
                gcd_start  = 1'b1;
                state_next = ST_GCD;
            end
            ST_GCD: begin
                if (gcd_res.done) begin
                    if (!gcd_res.coprime) begin
                        cand_next  = cand_inc;
                        state_next = ST_CHECK;
                    end else if (idx_inc == count_reg) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                        cand_next  = cand_inc;
                        res_next.modulus  = MODULUS_W'(64'(cand_reg[MODULUS_BITS-1:0]));
                        res_next.position = POSITION_W'(64'(count_reg));
                        res_next.last     = (count_e + EW'(1) == eff);
                        res_next.status   = STATUS_OK;
                        state_next = ST_RESP;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cand_reg      <= '0;
            first_odd_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cand_reg      <= cand_next;
            first_odd_reg <= first_odd_next;
        end
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);
    assign res       = res_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_MODULI))
        else $error("accepted count beyond table depth");

    a_fail_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status != STATUS_OK |->
            res.modulus == '0 && res.position == '0 && !res.last)
        else $error("non-ok result carries data");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid && req_ready |=> !req_ready)
        else $error("sequencer idle right after taking a request");

    a_search_write_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en && state_reg == ST_GCD |-> wr_data[0] && count_reg != '0)
        else $error("searched modulus written even or into empty set");

    a_gcd_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        gcd_res.done |-> state_reg == ST_GCD)
        else $error("gcd finished outside its wait state");

endmodule

// ===== sim/cmg_result_checker.sv =====
`timescale 1ns / 100ps

// Watches the request, result and register channels of the moduli generator.
// It keeps its own copy of the modulus set and the registers, works out the
// result word for each accepted request and compares it with what comes out.
module cmg_result_checker import cmg_pkg::*; #(
    parameter int MAX_MODULI   = DEF_MAX_MODULI,
    parameter int MODULUS_BITS = DEF_MODULUS_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_DATA_W-1:0]    s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_DATA_W-1:0]    m_tdata,
    input  logic                   m_tlast,
    input  logic [M_USER_W-1:0]    m_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int unsigned            mismatches,
    output int unsigned            outstanding
);

    localparam longint unsigned CAND_LIMIT = 64'd1 << MODULUS_BITS;

    longint unsigned       moduli_tab [MAX_MODULI];
    int unsigned           n_moduli;
    longint unsigned       cand_next;
    logic [MODULUS_W-1:0]  first_mod;
    logic [SET_SIZE_W-1:0] size_reg;
    result_t               pending_moduli_q [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic longint unsigned euclid_gcd(input longint unsigned a,
                                                   input longint unsigned b);
        longint unsigned x;
        longint unsigned y;
        longint unsigned t;
        x = a;
        y = b;
        while (x != 0) begin
            t = y % x;
            y = x;
            x = t;
        end
        return y;
    endfunction

    // Advances the set by one request and returns the word it should produce.
    function automatic result_t predict_modulus(input logic restart);
        result_t         word;
        int unsigned     eff;
        longint unsigned cand;
        bit              found;
        bit              coprime;
        int unsigned     i;
        word        = '0;
        word.status = STATUS_OK;
        eff = (size_reg == 0) ? 1 : size_reg;
        if (eff > MAX_MODULI)
            eff = MAX_MODULI;

        if (restart || n_moduli == 0) begin
            // an empty set treats a plain request as a restart
            n_moduli = 0;
            if (64'(first_mod) >= CAND_LIMIT) begin
                word.status = STATUS_OVERFLOW;
            end else begin
                moduli_tab[0] = 64'(first_mod);
                n_moduli      = 1;
                cand_next     = 64'(first_mod) + 64'd2;
                word.modulus  = first_mod;
                word.last     = (eff <= 1);
            end
        end else if (n_moduli >= eff) begin
            word.status = STATUS_COMPLETE;
        end else if (!moduli_tab[0][0]) begin
            // even base: every odd step stays even, so the search can only overflow
            word.status = STATUS_OVERFLOW;
        end else begin
            cand  = cand_next;
            found = 1'b0;
            while (!found && cand < CAND_LIMIT) begin
                coprime = 1'b1;
                for (i = 0; i < n_moduli && coprime; i++)
                    if (euclid_gcd(moduli_tab[i], cand) > 1)
                        coprime = 1'b0;
                if (coprime)
                    found = 1'b1;
                else
                    cand += 2;
            end
            if (!found) begin
                // state kept, so later requests overflow again until a restart
                cand_next   = cand;
                word.status = STATUS_OVERFLOW;
            end else begin
                moduli_tab[n_moduli] = cand;
                word.modulus  = cand[MODULUS_W-1:0];
                word.position = n_moduli[POSITION_W-1:0];
                n_moduli++;
                cand_next = cand + 64'd2;
                word.last = (n_moduli == eff);
            end
        end
        return word;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : monitor
        result_t want;
        if (!aresetn) begin
            first_mod = FIRST_MODULUS_RST;
            size_reg  = SET_SIZE_RST;
            n_moduli  = 0;
            cand_next = 0;
            pending_moduli_q.delete();
        end else begin
            // results first: a word leaving now never belongs to a request taken now
            if (m_tvalid && m_tready) begin
                if (pending_moduli_q.size() == 0) begin
                    report_mismatch("unexpected result word", m_tdata, 0);
                end else begin
                    want = pending_moduli_q.pop_front();
                    if (m_tdata[MODULUS_W-1:0] !== want.modulus)
                        report_mismatch("modulus", m_tdata[MODULUS_W-1:0], want.modulus);
                    if (m_tdata[MODULUS_W +: POSITION_W] !== want.position)
                        report_mismatch("position", m_tdata[MODULUS_W +: POSITION_W],
                                        want.position);
                    if (m_tlast !== want.last)
                        report_mismatch("last", m_tlast, want.last);
                    if (m_tuser !== want.status)
                        report_mismatch("status", m_tuser, want.status);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_FIRST_MODULUS)
                    first_mod = cfg_data[MODULUS_W-1:0];
                else if (cfg_index == CFG_SET_SIZE)
                    size_reg = cfg_data[SET_SIZE_W-1:0];
            end
            if (s_tvalid && s_tready)
                pending_moduli_q.push_back(predict_modulus(s_tdata[0]));
        end
        outstanding <= pending_moduli_q.size();
    end

endmodule

// ===== sim/tb_coprime_moduli_generator_unit.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the coprime moduli generator. The checker beside
// the block does all prediction; this module only feeds words, writes the
// registers between phases and decides pass or fail.
module tb_coprime_moduli_generator_unit import cmg_pkg::*;;

    localparam int ITEM_TARGET    = 300;     // request words, directed plus random
    localparam int HOLD_CYCLES    = 300;     // one long receiver stall
    localparam int WATCHDOG_LIMIT = 200000;  // cycles without any handshake
    localparam int DRAIN_CYCLES   = 50;      // watch for stray words at the end

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tlast;
    logic [M_USER_W-1:0]    m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int unsigned mismatches;
    int unsigned outstanding;

    int items_sent   = 0;
    int quiet_cycles = 0;
    int calm [2]     = '{0, 0};  // per side: words left in a no-idle stretch
    bit hold_req     = 1'b0;     // set by stimulus, served once by the receiver
    bit hold_done    = 1'b0;

    // 2 ns clock
    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    coprime_moduli_generator_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [0] restart, [7:1] zero
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [31:0] modulus, [38:32] position, [39] zero
        .m_tlast   (m_tlast),    // modulus completes the set
        .m_tuser   (m_tuser),    // [1:0] status
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cmg_result_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Idle cycles before the next word on one side (0 sender, 1 receiver).
    // Now and then a stretch of back-to-back words with no idling at all.
    function automatic int draw_gap(input int side);
        int gap;
        gap = 0;
        if (calm[side] > 0) begin
            calm[side]--;
        end else begin
            if ($urandom_range(0, 11) == 0)
                calm[side] = $urandom_range(8, 40);
            gap = $urandom_range(0, 5);
        end
        return gap;
    endfunction

    // Offer one request word; entered and left at a falling edge. tvalid stays
    // high on return so back-to-back words need no drop.
    task automatic send_request(input bit restart);
        int gap;
        gap = draw_gap(0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(restart);
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Register writes only happen here, with the block idle.
    task automatic configure(input bit do_first, input logic [CFG_DATA_W-1:0] first_val,
                             input bit do_size, input logic [CFG_DATA_W-1:0] size_val);
        if (do_first)
            write_reg(CFG_FIRST_MODULUS, first_val);
        if (do_size)
            write_reg(CFG_SET_SIZE, size_val);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
    endtask

    // Receiver: random tready gaps per word, plus one long hold while the
    // sender keeps going, which backs the block up into its input.
    initial begin : receiver
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            gap = draw_gap(1);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // Watchdog: any accepted word on any channel restarts the count.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int                    phase;
        int                    kind;
        int                    n;
        int                    k;
        int unsigned           eff;
        int unsigned           size_val;
        int unsigned           cur_size;
        logic [CFG_DATA_W-1:0] first_word;
        logic [CFG_DATA_W-1:0] size_word;
        bit                    wr_first;
        bit                    wr_size;
        bit                    restart;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ---------------- directed ----------------
        // Reset registers; a plain request on the empty set starts it,
        // then one search step and a restart.
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        settle();

        // Widest odd base; set size 0 counts as one, so the next request
        // reports the set as complete.
        configure(1'b1, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
        send_request(1'b1);
        send_request(1'b0);
        settle();

        // Size 3 on the same base: the first candidate is past 32 bits,
        // overflow twice (state kept), then a restart recovers.
        configure(1'b0, '0, 1'b1, 32'd3);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        settle();

        // One odd step below the top: 0xFFFFFFFF is coprime and fits, the
        // step after overflows. Size field 255 (all upper data bits set too)
        // clamps to the table depth.
        configure(1'b1, 32'hFFFF_FFFD, 1'b1, 32'hFFFF_FFFF);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        settle();

        // Even bases: zero and the largest even value; the restart returns the base, the next request overflows.
        configure(1'b1, 32'h0000_0000, 1'b1, 32'd2);
        send_request(1'b1);
        send_request(1'b0);
        settle();
        configure(1'b1, 32'hFFFF_FFFE, 1'b0, '0);
        send_request(1'b1);
        send_request(1'b0);
        settle();

        // Base 1 is coprime with everything; fill a set of four, then complete.
        // Upper data bits on the size write must be ignored.
        configure(1'b1, 32'd1, 1'b1, 32'h1234_5604);
        send_request(1'b1);
        for (k = 0; k < 4; k++)
            send_request(1'b0);
        cur_size = 4;

        // ---------------- random phases ----------------
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            if (phase == 0) begin
                // one full set up to the last position; small odd base keeps
                // each gcd short
                first_word = 2 * $urandom_range(0, 40) + 1;
                size_val   = $urandom_range(0, 1) ? 128 : 255;
                wr_first   = 1'b1;
                wr_size    = 1'b1;
            end else begin
                kind = (phase == 1) ? 0 : $urandom_range(0, 9);
                case (kind)
                    0, 1, 2, 3: begin
                        first_word = $urandom_range(1, 2047) | 1;
                        size_val   = $urandom_range(1, 12);
                    end
                    4, 5, 6: begin
                        first_word = $urandom | 1;
                        size_val   = $urandom_range(1, 6);
                    end
                    7: begin
                        first_word = 32'hFFFF_FFFF - 2 * $urandom_range(0, 30);
                        size_val   = $urandom_range(2, 8);
                    end
                    8: begin
                        first_word = $urandom & 32'hFFFF_FFFE;
                        size_val   = $urandom_range(1, 4);
                    end
                    default: begin
                        first_word = $urandom;
                        size_val   = $urandom_range(1, 6);
                    end
                endcase
                if ($urandom_range(0, 9) == 0)
                    size_val = 0;
                // sometimes keep one register, so a set can continue under new settings
                wr_first = ($urandom_range(0, 5) != 0);
                wr_size  = ($urandom_range(0, 5) != 0);
                if (phase == 1) begin
                    // the long hold needs a run of several words behind it
                    size_val = 8;
                    wr_first = 1'b1;
                    wr_size  = 1'b1;
                end
            end
            size_word = ($urandom & 32'hFFFF_FF00) | size_val;
            configure(wr_first, first_word, wr_size, size_word);
            if (wr_size)
                cur_size = size_val;
            eff = (cur_size == 0) ? 1 : ((cur_size > 128) ? 128 : cur_size);
            if (phase == 1)
                hold_req = 1'b1;

            // a run: a restart (always in phase 0, mostly later), requests up to and
            // sometimes past completion, and after phase 0 the odd stray restart as noise
            n = (phase == 0) ? eff + 2 : eff + $urandom_range(0, 2);
            for (k = 0; k < n; k++) begin
                if (k == 0)
                    restart = (phase == 0) || ($urandom_range(0, 3) != 0);
                else
                    restart = (phase != 0) && ($urandom_range(0, 14) == 0);
                send_request(restart);
            end
            phase++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/cmg_pkg.sv
hdl/cmg_ram.sv
hdl/cmg_gcd.sv
hdl/cmg_search.sv
hdl/coprime_moduli_generator_unit.sv
sim/cmg_result_checker.sv
sim/tb_coprime_moduli_generator_unit.sv
